// ===== rtl/asrb_pkg.sv =====
// Shared constants, types and opcodes for the audio sample ring buffer.
`timescale 1ns / 1ps

package asrb_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int OUT_BITS    = 16;

   typedef enum logic [2:0] {
      OP_APPEND     = 3'd0,
      OP_POP        = 3'd1,
      OP_PEEK       = 3'd2,
      OP_DISCARD    = 3'd3,
      OP_COMMIT     = 3'd4,
      OP_STORE_FREE = 3'd5,
      OP_SET_LENGTH = 3'd6,
      OP_RESET      = 3'd7
   } opcode_type;

   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic [COUNT_BITS-1:0]         count_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

endpackage

// ===== rtl/asrb_if.sv =====
// Handshake channel interfaces: request, response and capacity register write.
`timescale 1ns / 1ps

interface asrb_req_if;
   logic                   valid;
   logic                   ready;
   asrb_pkg::opcode_type   opcode;
   logic signed [15:0]     sample_in;
   logic [10:0]            amount;
   modport source (output valid, output opcode, output sample_in, output amount, input ready);
   modport sink   (input valid, input opcode, input sample_in, input amount, output ready);
endinterface

interface asrb_rsp_if;
   logic                   valid;
   logic                   ready;
   logic signed [15:0]     sample_out;
   logic                   status;
   logic [10:0]            fill_level;
   modport source (output valid, output sample_out, output status, output fill_level,
                   input ready);
   modport sink   (input valid, input sample_out, input status, input fill_level,
                   output ready);
endinterface

interface asrb_csr_if;
   logic                   valid;
   logic                   ready;
   logic [10:0]            buffer_capacity;
   modport source (output valid, output buffer_capacity, input ready);
   modport sink   (input valid, input buffer_capacity, output ready);
endinterface

// ===== rtl/asrb_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module asrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/audio_sample_ring_buffer.sv =====
// Audio sample ring buffer: logical circular store with pointer and fill count.
//
//   channel | dir | beat                               | accepted when
//   req     | in  | opcode, sample_in, amount          | valid & ready
//   rsp     | out | sample_out, status, fill_level     | valid & ready
//   csr     | in  | buffer_capacity                    | valid & ready (ready always high)
//
// One beat per cycle while req.ready is high; each result passes through the RAM stage
// (pointer update and RAM access), then the output register, before its response
// beat is offered.
// After reset the store is zeroed one slot a cycle: req.ready stays low until all
// STORE_DEPTH (1024) slots are cleared. Capacity writes are taken throughout.
// A stalled response holds the output register; one further request is taken
// into the RAM stage before req.ready drops.
`timescale 1ns / 1ps

module audio_sample_ring_buffer (
   input  logic clock,
   input  logic reset,
   asrb_req_if.sink   req_bus,
   asrb_rsp_if.source rsp_bus,
   asrb_csr_if.sink   csr_bus
);
   import asrb_pkg::*;

   localparam int SUM_BITS = COUNT_BITS + 1;

   addr_type   rp_ff, rp_in;
   count_type  fill_ff, fill_in;
   count_type  cap_ff;
   count_type  csr_cap;
   logic       clear_busy_ff;
   addr_type   clear_addr_ff;

   logic                 s1_valid_ff, s1_read_ff, s1_status_ff;
   count_type            s1_fill_ff;
   logic                 out_valid_ff, out_status_ff;
   logic [OUT_BITS-1:0]  out_sample_ff;
   count_type            out_fill_ff;

   logic                 accept, advance;
   logic                 fail, do_read, do_write, use_rp;
   logic [SUM_BITS-1:0]  offset, phys_sum;
   addr_type             phys_addr;
   logic                 ram_wr_en;
   addr_type             ram_wr_addr;
   sample_type           ram_wr_data, ram_rd_data;
   addr_type             ram_rd_addr;

   // effective capacity clamped to [1, STORE_DEPTH]
   always_comb begin
      csr_cap = csr_bus.buffer_capacity;
      if (csr_bus.buffer_capacity == '0) begin
         csr_cap = count_type'(1);
      end else if (csr_bus.buffer_capacity > count_type'(STORE_DEPTH)) begin
         csr_cap = count_type'(STORE_DEPTH);
      end
   end

   assign advance         = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready   = !clear_busy_ff && (!s1_valid_ff || advance);
   assign accept          = req_bus.valid && req_bus.ready;
   assign csr_bus.ready   = 1'b1;

   // logical offset to slot: one wrap at most
   always_comb begin
      phys_sum = {{(SUM_BITS-ADDR_BITS){1'b0}}, rp_ff} + offset;
      if (phys_sum >= {1'b0, cap_ff}) begin
         phys_sum = phys_sum - {1'b0, cap_ff};
      end
      phys_addr = phys_sum[ADDR_BITS-1:0];
   end

   always_comb begin
      fail     = 1'b0;
      do_read  = 1'b0;
      do_write = 1'b0;
      use_rp   = 1'b0;
      offset   = {1'b0, fill_ff};
      rp_in    = rp_ff;
      fill_in  = fill_ff;
      case (req_bus.opcode)
         OP_APPEND: begin
            fail     = fill_ff >= cap_ff;
            do_write = !fail;
            if (!fail) begin
               fill_in = fill_ff + count_type'(1);
            end
         end
         OP_POP: begin
            offset  = SUM_BITS'(1);
            use_rp  = 1'b1;
            fail    = fill_ff == '0;
            do_read = !fail;
            if (!fail) begin
               if (fill_ff == count_type'(1)) begin
                  rp_in   = '0;
                  fill_in = '0;
               end else begin
                  rp_in   = phys_addr;
                  fill_in = fill_ff - count_type'(1);
               end
            end
         end
         OP_PEEK: begin
            offset  = {1'b0, req_bus.amount};
            fail    = req_bus.amount >= fill_ff;
            do_read = !fail;
         end
         OP_DISCARD: begin
            offset = {1'b0, req_bus.amount};
            if (req_bus.amount >= fill_ff) begin
               rp_in   = '0;
               fill_in = '0;
            end else begin
               rp_in   = phys_addr;
               fill_in = fill_ff - req_bus.amount;
            end
         end
         OP_COMMIT: begin
            fail = ({1'b0, req_bus.amount} + {1'b0, fill_ff}) > {1'b0, cap_ff};
            if (!fail) begin
               fill_in = fill_ff + req_bus.amount;
            end
         end
         OP_STORE_FREE: begin
            offset   = {1'b0, fill_ff} + {1'b0, req_bus.amount};
            fail     = req_bus.amount >= (cap_ff - fill_ff);
            do_write = !fail;
         end
         OP_SET_LENGTH: begin
            fill_in = (req_bus.amount > cap_ff) ? cap_ff : req_bus.amount;
         end
         OP_RESET: begin
            rp_in   = '0;
            fill_in = '0;
         end
         default: begin
            rp_in   = '0;
            fill_in = '0;
         end
      endcase
   end

   assign ram_wr_en   = clear_busy_ff || (accept && do_write);
   assign ram_wr_addr = clear_busy_ff ? clear_addr_ff : phys_addr;
   assign ram_wr_data = clear_busy_ff ? sample_type'(0) : sample_type'(req_bus.sample_in);
   assign ram_rd_addr = use_rp ? rp_ff : phys_addr;

   asrb_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept && do_read),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // pointer, length, capacity and clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff         <= '0;
         fill_ff       <= '0;
         cap_ff        <= count_type'(STORE_DEPTH);
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         if (clear_busy_ff) begin
            clear_addr_ff <= clear_addr_ff + addr_type'(1);
            if (clear_addr_ff == addr_type'(STORE_DEPTH - 1)) begin
               clear_busy_ff <= 1'b0;
            end
         end
         if (csr_bus.valid) begin
            cap_ff  <= csr_cap;
            rp_ff   <= '0;
            fill_ff <= '0;
         end else if (accept) begin
            rp_ff   <= rp_in;
            fill_ff <= fill_in;
         end
      end
   end

   // RAM stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_ff   <= do_read;
         s1_status_ff <= fail;
         s1_fill_ff   <= fill_in;
      end
      if (advance) begin
         out_sample_ff <= s1_read_ff ? OUT_BITS'(ram_rd_data) : '0;
         out_status_ff <= s1_status_ff;
         out_fill_ff   <= s1_fill_ff;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.sample_out = out_sample_ff;
   assign rsp_bus.status     = out_status_ff;
   assign rsp_bus.fill_level = out_fill_ff;

endmodule

// ===== tb/ring_check_pkg.sv =====
// Scoreboard for the audio sample ring buffer: occupancy tracker and result matcher.
`timescale 1ns / 1ps

package ring_check_pkg;
   import asrb_pkg::*;

   typedef struct {
      opcode_type op;
      sample_type smp;
      count_type  amt;
   } ring_request_type;

   typedef struct {
      sample_type smp;
      logic       too_big;
      count_type  level;
   } ring_result_type;

   class ring_buffer_tracker;
      sample_type      slots [STORE_DEPTH];
      int unsigned     rd_ptr;
      int unsigned     fill;
      int unsigned     cap_reg;
      ring_result_type awaited [$];
      int unsigned     failures;
      int unsigned     requests;
      int unsigned     checked;
      int unsigned     too_big_seen;

      function new();
         foreach (slots[i]) slots[i] = '0;
         rd_ptr       = 0;
         fill         = 0;
         cap_reg      = STORE_DEPTH;
         failures     = 0;
         requests     = 0;
         checked      = 0;
         too_big_seen = 0;
      endfunction

      function int unsigned capacity();
         int unsigned c;
         c = cap_reg;
         if (c == 0) c = 1;
         if (c > STORE_DEPTH) c = STORE_DEPTH;
         return c;
      endfunction

      function void write_capacity(int unsigned value);
         cap_reg = value & 'h7ff;
         rd_ptr  = 0;
         fill    = 0;
      endfunction

      function int unsigned slot_of(int unsigned k, int unsigned c);
         int unsigned a;
         a = rd_ptr + k;
         while (a >= c) a -= c;
         return a % STORE_DEPTH;
      endfunction

      function void drop(int unsigned n, int unsigned c);
         if (n >= fill) begin
            rd_ptr = 0;
            fill   = 0;
         end else begin
            rd_ptr = slot_of(n, c);
            fill   = fill - n;
         end
      endfunction

      function void take_request(ring_request_type rq);
         ring_result_type res;
         int unsigned     c;
         int unsigned     a;
         c           = capacity();
         a           = rq.amt;
         res.smp     = '0;
         res.too_big = 1'b0;
         requests++;
         if (rd_ptr >= c) rd_ptr = 0;
         if (fill > c) fill = c;
         case (rq.op)
            OP_APPEND: begin
               if (fill >= c) res.too_big = 1'b1;
               else begin
                  slots[slot_of(fill, c)] = rq.smp;
                  fill++;
               end
            end
            OP_POP: begin
               if (fill == 0) res.too_big = 1'b1;
               else begin
                  res.smp = slots[slot_of(0, c)];
                  drop(1, c);
               end
            end
            OP_PEEK: begin
               if (a + 1 > fill) res.too_big = 1'b1;
               else res.smp = slots[slot_of(a, c)];
            end
            OP_DISCARD: drop(a, c);
            OP_COMMIT: begin
               if (a + fill > c) res.too_big = 1'b1;
               else fill += a;
            end
            OP_STORE_FREE: begin
               if (a >= c - fill) res.too_big = 1'b1;
               else slots[slot_of(fill + a, c)] = rq.smp;
            end
            OP_SET_LENGTH: fill = (a > c) ? c : a;
            default: begin
               rd_ptr = 0;
               fill   = 0;
            end
         endcase
         if (res.too_big) too_big_seen++;
         res.level = count_type'(fill);
         awaited.push_back(res);
      endfunction

      function void match_response(sample_type smp, logic too_big, count_type level);
         ring_result_type want;
         if (awaited.size() == 0) begin
            $error("response beat with no request outstanding");
            failures++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (smp !== want.smp) begin
            $error("sample_out: expected %0d, got %0d", want.smp, smp);
            failures++;
         end
         if (too_big !== want.too_big) begin
            $error("status: expected %0d, got %0d", want.too_big, too_big);
            failures++;
         end
         if (level !== want.level) begin
            $error("fill_level: expected %0d, got %0d", want.level, level);
            failures++;
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for the audio sample ring buffer.
`timescale 1ns / 1ps

module tb_top;
   import asrb_pkg::*;
   import ring_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 6;
   localparam int PHASE_ITEMS    = 155;
   localparam int PHASES         = 9;

   logic clock;
   logic reset;

   asrb_req_if req_bus ();
   asrb_rsp_if rsp_bus ();
   asrb_csr_if csr_bus ();

   ring_buffer_tracker tracker;

   int unsigned send_gap_pct   = 28;
   int unsigned recv_stall_pct = 60;
   int unsigned holds_asked    = 0;
   int unsigned holds_done     = 0;
   int unsigned hold_left      = 0;
   int unsigned quiet_cycles   = 0;

   audio_sample_ring_buffer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.match_response(rsp_bus.sample_out, rsp_bus.status, rsp_bus.fill_level);
         if (holds_done != holds_asked) begin
            hold_left  = HOLD_CYCLES;
            holds_done = holds_asked;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("audio_sample_ring_buffer regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input opcode_type op, input int unsigned smp,
                               input int unsigned amt);
      ring_request_type rq;
      rq.op  = op;
      rq.smp = sample_type'(smp);
      rq.amt = count_type'(amt);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= rq.op;
      req_bus.sample_in <= rq.smp;
      req_bus.amount    <= rq.amt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.take_request(rq);
   endtask

   task automatic write_capacity(input int unsigned value);
      csr_bus.valid           <= 1'b1;
      csr_bus.buffer_capacity <= value[10:0];
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      tracker.write_capacity(value);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed traffic relative to the tracked fill, some out-of-range noise
   task automatic random_request();
      int unsigned c;
      int unsigned f;
      int unsigned pick;
      int unsigned amt;
      int unsigned smp;
      bit          sane;
      opcode_type  op;
      c    = tracker.capacity();
      f    = tracker.fill;
      pick = $urandom_range(0, 99);
      sane = ($urandom_range(0, 99) < 75);
      smp  = $urandom_range(0, 65535);
      amt  = $urandom_range(0, 2047);
      if (pick < 28) begin
         op = OP_APPEND;
      end else if (pick < 46) begin
         op = OP_POP;
      end else if (pick < 60) begin
         op = OP_PEEK;
         if (sane) amt = (f == 0) ? 0 : $urandom_range(0, f - 1);
      end else if (pick < 68) begin
         op = OP_DISCARD;
         if (sane) amt = $urandom_range(0, f);
      end else if (pick < 75) begin
         op = OP_COMMIT;
         if (sane) amt = $urandom_range(0, c - f);
      end else if (pick < 83) begin
         op = OP_STORE_FREE;
         if (sane) amt = (c == f) ? 0 : $urandom_range(0, c - f - 1);
      end else if (pick < 90) begin
         op = OP_SET_LENGTH;
         if (sane) amt = $urandom_range(0, c);
      end else if (pick < 93) begin
         op = OP_RESET;
      end else begin
         op = opcode_type'($urandom_range(0, 7));
      end
      send_request(op, smp, amt);
   endtask

   initial begin
      int unsigned caps [PHASES];
      tracker                 = new();
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.opcode          = OP_APPEND;
      req_bus.sample_in       = '0;
      req_bus.amount          = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.buffer_capacity = '0;
      caps = '{0, 1, 2, 7, 2047, 33, 1024, 1023, 0};
      caps[PHASES-1] = $urandom_range(1, 2047);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: a four-slot ring, full/empty edges, wrap, saturation
      write_capacity(4);
      send_request(OP_POP,        0,      0);
      send_request(OP_PEEK,       0,      0);
      send_request(OP_APPEND,     'h8000, 0);
      send_request(OP_APPEND,     'h7fff, 2047);
      send_request(OP_APPEND,     0,      0);
      send_request(OP_APPEND,     'hffff, 1024);
      send_request(OP_APPEND,     1,      0);
      send_request(OP_PEEK,       0,      3);
      send_request(OP_PEEK,       0,      4);
      send_request(OP_PEEK,       0,      2047);
      send_request(OP_POP,        0,      0);
      send_request(OP_APPEND,     'h1234, 0);
      send_request(OP_STORE_FREE, 'h5555, 0);
      send_request(OP_POP,        0,      0);
      send_request(OP_POP,        0,      0);
      send_request(OP_STORE_FREE, 'haaaa, 1);
      send_request(OP_COMMIT,     0,      2);
      send_request(OP_COMMIT,     0,      1);
      send_request(OP_PEEK,       0,      3);
      send_request(OP_DISCARD,    0,      1);
      send_request(OP_DISCARD,    0,      2047);
      send_request(OP_SET_LENGTH, 0,      2047);
      send_request(OP_PEEK,       0,      1);
      send_request(OP_SET_LENGTH, 0,      0);
      send_request(OP_APPEND,     'h0f0f, 0);
      send_request(OP_RESET,      0,      0);
      send_request(OP_COMMIT,     0,      0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         if (p < 3) begin
            send_gap_pct   <= 28;
            recv_stall_pct <= 60;
         end else if (p < 6) begin
            send_gap_pct   <= 60;
            recv_stall_pct <= 28;
         end else begin
            send_gap_pct   <= 0;
            recv_stall_pct <= 0;
         end
         write_capacity(caps[p]);
         if (p == 6) holds_asked <= holds_asked + 1;
         for (int i = 0; i < PHASE_ITEMS; i++) random_request();
         settle();
      end

      $display("%0d requests, %0d responses checked across %0d capacity settings",
               tracker.requests, tracker.checked, PHASES + 1);
      $display("%0d too-big answers seen; one %0d-cycle response back-pressure stretch",
               tracker.too_big_seen, HOLD_CYCLES);
      if (tracker.failures == 0 && tracker.awaited.size() == 0) begin
         $display("audio_sample_ring_buffer regression: pass");
      end else begin
         $display("audio_sample_ring_buffer regression: fail");
      end
      $finish;
   end

endmodule
